// ----- rtl/pidpr_pkg.sv -----
// Package for the PID power regulator: widths, limits and register indexes.
package pidpr_pkg;

  // Field widths
  localparam int unsigned CurW   = 16;  // Q8.8 current
  localparam int unsigned GainW  = 16;  // unsigned Q8.8 gain
  localparam int unsigned ErrW   = 17;  // setpoint - measurement
  localparam int unsigned IntW   = 16;  // error integral
  localparam int unsigned DiffW  = 18;  // error - previous error
  localparam int unsigned RunW   = 5;   // negative run counter
  localparam int unsigned DriveW = 10;  // drive level

  // Product and sum widths (signed)
  localparam int unsigned ProdPW = 34;  // 17 x 17
  localparam int unsigned ProdIW = 33;  // 17 x 16
  localparam int unsigned ProdDW = 35;  // 17 x 18
  localparam int unsigned BoostW = 39;  // derivative times ten
  localparam int unsigned PiW    = 35;  // P + I
  localparam int unsigned TotW   = 41;  // P + I + D
  localparam int unsigned FracW  = 16;  // Q16.16 fraction bits

  // Limits
  localparam logic [RunW-1:0]   RunLimit  = 5'd15;
  localparam logic [RunW-1:0]   RunSat    = 5'd31;
  localparam logic signed [17:0] IntLimit = 18'sd25600;
  localparam logic [DriveW-1:0] DriveMax  = 10'd900;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SETPOINT = 2'd0,
    CFG_GAIN_P   = 2'd1,
    CFG_GAIN_I   = 2'd2,
    CFG_GAIN_D   = 2'd3
  } cfg_idx_t;

endpackage

// ----- rtl/pid_power_regulator.sv -----
// PID power regulator: current error to clamped dimmer drive, six-stage pipeline.
// Throughput: one item per cycle while out_ready allows; stage 1 updates run counter, integral and
//   previous error together as each item enters, the multipliers and adds after it are pipelined.
// Each stage holds its item while the next cannot take it, so bubbles fill under stall.
// Reset (rst_n low, synchronous): stage valids, config registers and loop state clear.
module pid_power_regulator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [pidpr_pkg::CurW-1:0] in_measured_current,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pidpr_pkg::DriveW-1:0]     out_drive_power,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [15:0]                      cfg_data
);
  import pidpr_pkg::*;

  // Configuration registers
  logic signed [CurW-1:0] setpoint_r;
  logic [GainW-1:0]       gain_p_r, gain_i_r, gain_d_r;

  // Loop state
  logic signed [IntW-1:0] integ_r, integ_nxt;
  logic [RunW-1:0]        run_r, run_nxt;
  logic signed [ErrW-1:0] prev_err_r;

  // Stage valids and readiness
  logic [5:0] v_r;
  logic [5:0] rdy;

  // Stage payloads
  logic signed [CurW-1:0]   meas_r;
  logic signed [ErrW-1:0]   err1_r, err_nxt;
  logic signed [IntW-1:0]   integ1_r;
  logic signed [DiffW-1:0]  diff1_r, diff_nxt;
  logic signed [ProdPW-1:0] prod_p_r, prod_p_nxt;
  logic signed [ProdIW-1:0] prod_i_r, prod_i_nxt;
  logic signed [ProdDW-1:0] prod_d_r, prod_d_nxt;
  logic                     err_pos2_r;
  logic signed [PiW-1:0]    pi_r, pi_nxt;
  logic signed [BoostW-1:0] dterm_r, dterm_nxt;
  logic signed [TotW-1:0]   total_r, total_nxt;
  logic [DriveW-1:0]        drive_r, drive_nxt;

  logic signed [17:0]       sum_i;
  logic signed [IntW-1:0]   integ_base;
  logic signed [BoostW-1:0] d_ext;
  logic [TotW-FracW-1:0]    total_int;

  // Readiness chain: a stage takes an item when empty or when it passes its own on
  assign rdy[5] = !v_r[5] || out_ready;
  assign rdy[4] = !v_r[4] || rdy[5];
  assign rdy[3] = !v_r[3] || rdy[4];
  assign rdy[2] = !v_r[2] || rdy[3];
  assign rdy[1] = !v_r[1] || rdy[2];
  assign rdy[0] = !v_r[0] || rdy[1];
  assign in_ready = rdy[0];

  // Stage 1: error, run counter, integral with limit, derivative difference
  always_comb begin
    err_nxt = ErrW'(setpoint_r) - ErrW'(meas_r);
    if (err_nxt[ErrW-1]) begin
      run_nxt = (run_r < RunSat) ? run_r + 1'b1 : run_r;
    end else begin
      run_nxt = '0;
    end
    integ_base = (run_nxt > RunLimit) ? '0 : integ_r;
    sum_i = 18'(integ_base) + 18'(err_nxt);
    if (sum_i <= IntLimit && sum_i >= -IntLimit) begin
      integ_nxt = sum_i[IntW-1:0];
    end else begin
      integ_nxt = integ_base;
    end
    diff_nxt = DiffW'(err_nxt) - DiffW'(prev_err_r);
  end

  // Stage 2: gain products
  always_comb begin
    prod_p_nxt = $signed({1'b0, gain_p_r}) * err1_r;
    prod_i_nxt = $signed({1'b0, gain_i_r}) * integ1_r;
    prod_d_nxt = $signed({1'b0, gain_d_r}) * diff1_r;
  end

  // Stage 3: P + I, derivative boost when it opposes a positive error
  always_comb begin
    pi_nxt = PiW'(prod_p_r) + PiW'(prod_i_r);
    d_ext  = BoostW'(prod_d_r);
    if (prod_d_r[ProdDW-1] && err_pos2_r) begin
      dterm_nxt = (d_ext <<< 3) + (d_ext <<< 1);
    end else begin
      dterm_nxt = d_ext;
    end
  end

  // Stage 4: total
  assign total_nxt = TotW'(pi_r) + TotW'(dterm_r);

  // Stage 5: truncate to integer and clamp
  assign total_int = total_r[TotW-1:FracW];
  always_comb begin
    if (total_r[TotW-1] || total_r == '0) begin
      drive_nxt = '0;
    end else if (total_int > (TotW-FracW)'(DriveMax)) begin
      drive_nxt = DriveMax;
    end else begin
      drive_nxt = total_int[DriveW-1:0];
    end
  end

  // Control: config, stage valids, loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      gain_p_r   <= '0;
      gain_i_r   <= '0;
      gain_d_r   <= '0;
      v_r        <= '0;
      integ_r    <= '0;
      run_r      <= '0;
      prev_err_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SETPOINT: setpoint_r <= cfg_data;
          CFG_GAIN_P:   gain_p_r   <= cfg_data;
          CFG_GAIN_I:   gain_i_r   <= cfg_data;
          CFG_GAIN_D:   gain_d_r   <= cfg_data;
          default:      ;
        endcase
      end
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
      if (rdy[4]) v_r[4] <= v_r[3];
      if (rdy[5]) v_r[5] <= v_r[4];
      // State advances once per item as it enters stage 1
      if (v_r[0] && rdy[1]) begin
        integ_r    <= integ_nxt;
        run_r      <= run_nxt;
        prev_err_r <= err_nxt;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && rdy[0]) meas_r <= in_measured_current;
    if (v_r[0] && rdy[1]) begin
      err1_r   <= err_nxt;
      integ1_r <= integ_nxt;
      diff1_r  <= diff_nxt;
    end
    if (v_r[1] && rdy[2]) begin
      prod_p_r   <= prod_p_nxt;
      prod_i_r   <= prod_i_nxt;
      prod_d_r   <= prod_d_nxt;
      err_pos2_r <= !err1_r[ErrW-1] && (err1_r != '0);
    end
    if (v_r[2] && rdy[3]) begin
      pi_r    <= pi_nxt;
      dterm_r <= dterm_nxt;
    end
    if (v_r[3] && rdy[4]) total_r <= total_nxt;
    if (v_r[4] && rdy[5]) drive_r <= drive_nxt;
  end

  assign out_valid       = v_r[5];
  assign out_drive_power = drive_r;

  // Integral stays inside the 100 A window
  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= 16'sd25600) && (integ_r >= -16'sd25600))
    else $error("integral outside limit");

  // Drive never above full scale
  a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_power <= DriveMax))
    else $error("drive above limit");

  // Stage 1 error is the error stored as previous for the next item
  a_prev_err: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> (prev_err_r == err1_r))
    else $error("previous error out of step");

  // A nonzero negative run implies the last error was negative
  a_run_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r != '0) |-> prev_err_r[ErrW-1])
    else $error("run counter without negative error");

endmodule

// ----- bench/pid_power_regulator_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the PID power regulator: current samples in, drive levels checked against a predictor.
module pid_power_regulator_tb;
  import pidpr_pkg::*;

  localparam int DerivBoost = 10;  // negative D term gain while error is positive

  // Tracks regulator state and configuration and holds the expected drive levels
  class drive_checker;
    int errors = 0;
    logic signed [CurW-1:0] setpoint = '0;
    logic [GainW-1:0] gain_p = '0;
    logic [GainW-1:0] gain_i = '0;
    logic [GainW-1:0] gain_d = '0;
    int integral = 0;
    logic [RunW-1:0] neg_run = '0;
    int prev_err = 0;
    logic [DriveW-1:0] expected_drive[$];

    function void set_reg(cfg_idx_t idx, logic [15:0] d);
      case (idx)
        CFG_SETPOINT: setpoint = d;
        CFG_GAIN_P:   gain_p = d;
        CFG_GAIN_I:   gain_i = d;
        CFG_GAIN_D:   gain_d = d;
        default: ;
      endcase
    endfunction

    // Advance the loop state by one sample and queue the drive it yields
    function void note_sample(logic signed [CurW-1:0] meas);
      int err;
      int sum_i;
      longint prop;
      longint integ;
      longint deri;
      longint total;
      logic [DriveW-1:0] drive;
      err = int'(setpoint) - int'(meas);
      // negative run counter, saturating
      if (err < 0) begin
        if (neg_run != RunSat) neg_run++;
      end else begin
        neg_run = '0;
      end
      if (neg_run > RunLimit) integral = 0;
      // anti-windup: keep old integral if the sum leaves the band
      sum_i = integral + err;
      if (sum_i <= int'(IntLimit) && sum_i >= -int'(IntLimit)) integral = sum_i;
      prop  = longint'(gain_p) * longint'(err);
      integ = longint'(gain_i) * longint'(integral);
      deri  = longint'(gain_d) * (longint'(err) - longint'(prev_err));
      if (deri < 0 && err > 0) deri = deri * DerivBoost;
      total = prop + integ + deri;
      // truncate Q16.16 and clamp
      if (total <= 0) drive = '0;
      else if ((total >>> FracW) > longint'(DriveMax)) drive = DriveMax;
      else drive = DriveW'(total >>> FracW);
      prev_err = err;
      expected_drive.push_back(drive);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [DriveW-1:0] got);
      logic [DriveW-1:0] want;
      if (expected_drive.size() == 0) begin
        report($sformatf("drive %0d with no sample pending", got));
      end else begin
        want = expected_drive.pop_front();
        if (got !== want) report($sformatf("drive_power %0d, expected %0d", got, want));
      end
    endtask

    function int pending();
      return expected_drive.size();
    endfunction
  endclass

  localparam int SamplesPerPhase = 194;
  localparam int RandomPhases    = 8;
  localparam int HoldCycles      = 400;
  localparam int IdleLimit       = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CurW-1:0] in_measured_current = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DriveW-1:0] out_drive_power;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_SETPOINT;
  logic [15:0] cfg_data = '0;

  drive_checker sb;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  pid_power_regulator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_measured_current (in_measured_current),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_drive_power     (out_drive_power),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one sample and hold it until the block takes it
  task automatic send_sample(input logic signed [CurW-1:0] m);
    in_valid <= 1'b1;
    in_measured_current <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(m);
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and wait for every pending drive level
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_one(input cfg_idx_t idx, input logic [15:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic write_regs(input logic [15:0] sp, input logic [15:0] kp,
                            input logic [15:0] ki, input logic [15:0] kd);
    write_one(CFG_SETPOINT, sp);
    write_one(CFG_GAIN_P, kp);
    write_one(CFG_GAIN_I, ki);
    write_one(CFG_GAIN_D, kd);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_setpoint();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 12800));
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(8, 640));
    endcase
  endfunction

  // Samples near the setpoint (mode 0: anywhere), biased per burst so long negative runs occur
  function automatic logic signed [CurW-1:0] random_sample(input int mode);
    int sp;
    sp = int'(sb.setpoint);
    case (mode)
      0: return CurW'($urandom);
      1: return CurW'(sp + int'($urandom_range(1, 3000)));
      2: return CurW'(sp - int'($urandom_range(0, 3000)));
      default: return CurW'(sp + int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  // Stimulus
  initial begin : stimulus
    int n;
    int burst;
    int mode;
    int gap;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: measurement extremes
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    drain();

    // full gains, largest errors, saturated drive
    write_regs(16'h7fff, 16'hffff, 16'hffff, 16'hffff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh0000);
    drain();

    // most negative error, negative sum gives zero drive
    write_regs(16'h8000, 16'h0100, 16'h0000, 16'h0000);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    drain();

    // long negative run clears the integral, then the integral band, then D boost
    write_regs(16'h0000, 16'h0000, 16'h0040, 16'h0100);
    repeat (17) send_sample(16'sd300);
    repeat (3) send_sample(-16'sd10000);
    send_sample(-16'sd5000);
    drain();

    // random phases
    for (int ph = 0; ph < RandomPhases; ph++) begin
      write_regs(pick_setpoint(), pick_gain(), pick_gain(), pick_gain());
      n = 0;
      while (n < SamplesPerPhase) begin
        burst = $urandom_range(1, 40);
        if (burst > SamplesPerPhase - n) burst = SamplesPerPhase - n;
        mode = $urandom_range(0, 4);
        repeat (burst) begin
          send_sample(random_sample(mode));
          n++;
          if (ph == 2 && n == 60) hold_req = 1'b1;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) idle_gap(gap);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: changing stall patterns, one long hold-off on request
  initial begin : rx_pattern
    bit held;
    int mode;
    int len;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(8, 60);
        for (int k = 0; k < len; k++) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((k % 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_drive_power);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
rtl/pidpr_pkg.sv
rtl/pid_power_regulator.sv
bench/pid_power_regulator_tb.sv
